FILE: hw/rtl/lplt_pkg.sv
// Shared types, codes and character helpers for the list tokenizer.
package lplt_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int NEST_W    = 7;
  localparam int VAL_W     = 64;
  localparam int KIND_W    = 3;
  localparam int MODE_W    = 3;

  // Parser modes.
  localparam logic [MODE_W-1:0] M_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] M_NUM    = 3'd1;
  localparam logic [MODE_W-1:0] M_STR    = 3'd2;
  localparam logic [MODE_W-1:0] M_WORD   = 3'd3;
  localparam logic [MODE_W-1:0] M_NEEDWS = 3'd4;
  localparam logic [MODE_W-1:0] M_HUNT   = 3'd5;
  localparam logic [MODE_W-1:0] M_ERR    = 3'd6;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_NUM   = 3'd0;
  localparam logic [KIND_W-1:0] EV_SHDR  = 3'd1;
  localparam logic [KIND_W-1:0] EV_SBYTE = 3'd2;
  localparam logic [KIND_W-1:0] EV_WBYTE = 3'd3;
  localparam logic [KIND_W-1:0] EV_WEND  = 3'd4;
  localparam logic [KIND_W-1:0] EV_OPEN  = 3'd5;
  localparam logic [KIND_W-1:0] EV_CLOSE = 3'd6;
  localparam logic [KIND_W-1:0] EV_ERR   = 3'd7;

  // Error codes.
  localparam logic [VAL_W-1:0] ERR_OVERFLOW  = 64'd0;
  localparam logic [VAL_W-1:0] ERR_MALFORMED = 64'd1;
  localparam logic [VAL_W-1:0] ERR_TOO_DEEP  = 64'd2;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic [NEST_W-1:0] depth;
    logic              last;
  } event_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {CH_SPACE, CH_NL};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

endpackage

FILE: hw/rtl/lplt_if.sv
// Handshake channel interfaces for the input bytes, the events and the configuration write.
interface lplt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface lplt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [63:0] event_value;
  logic [6:0]  nesting_depth;
  logic        last_string_byte;
  modport source (output valid, event_kind, event_value, nesting_depth, last_string_byte,
                  input ready);
  modport sink   (input valid, event_kind, event_value, nesting_depth, last_string_byte,
                  output ready);
endinterface

interface lplt_cfg_if;
  logic valid;
  logic ready;
  logic hunt_for_start;
  modport source (output valid, hunt_for_start, input ready);
  modport sink   (input valid, hunt_for_start, output ready);
endinterface

FILE: hw/rtl/lplt_parse.sv
// Parser state registers and the per-byte next-state and event logic.
module lplt_parse import lplt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       restart,
  input  logic       hunt,
  output logic       ev_fire,
  output event_t     ev
);

  logic [MODE_W-1:0]  mode_r, mode_nxt, mode_c;
  logic [VAL_W-1:0]   acc_r, acc_nxt, acc_c;
  logic [VAL_W-1:0]   rem_r, rem_nxt, rem_c, rem_dec;
  logic [DEPTH_W-1:0] depth_r, depth_nxt, depth_c;
  logic               slp_r, slp_nxt, slp_c;
  logic [VAL_W+3:0]   acc_x10;
  logic               acc_ovf;
  logic [VAL_W-1:0]   byte_val;

  // A restart clears the parse state before the byte is looked at.
  always_comb begin
    mode_c  = restart ? (hunt ? M_HUNT : M_IDLE) : mode_r;
    acc_c   = restart ? '0 : acc_r;
    rem_c   = restart ? '0 : rem_r;
    depth_c = restart ? '0 : depth_r;
    slp_c   = restart ? 1'b0 : slp_r;
  end

  // Multiply by ten as two shifted copies, plus the new digit; any carry
  // out of 64 bits is an overflow.
  assign acc_x10 = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0}
                 + {{VAL_W{1'b0}}, 4'(byte_in - CH_ZERO)};
  assign acc_ovf = |acc_x10[VAL_W+3:VAL_W];
  assign rem_dec = rem_c - VAL_W'(1);
  assign byte_val = {{(VAL_W - 8){1'b0}}, byte_in};

  always_comb begin
    mode_nxt  = mode_c;
    acc_nxt   = acc_c;
    rem_nxt   = rem_c;
    depth_nxt = depth_c;
    slp_nxt   = slp_c;
    ev_fire   = 1'b0;
    ev.kind   = EV_NUM;
    ev.value  = '0;
    ev.last   = 1'b0;

    case (mode_c)
      M_HUNT: begin
        if (slp_c && is_ws(byte_in)) begin
          slp_nxt   = 1'b0;
          depth_nxt = DEPTH_W'(1);
          mode_nxt  = M_IDLE;
          ev_fire   = 1'b1;
          ev.kind   = EV_OPEN;
        end else begin
          slp_nxt = (byte_in == CH_LPAREN);
        end
      end
      M_IDLE: begin
        if (is_ws(byte_in)) begin
          mode_nxt = M_IDLE;
        end else if (is_digit(byte_in)) begin
          acc_nxt  = {{(VAL_W - 4){1'b0}}, 4'(byte_in - CH_ZERO)};
          mode_nxt = M_NUM;
        end else if (is_alpha(byte_in)) begin
          mode_nxt = M_WORD;
          ev_fire  = 1'b1;
          ev.kind  = EV_WBYTE;
          ev.value = byte_val;
        end else if (byte_in == CH_LPAREN) begin
          ev_fire = 1'b1;
          if (depth_c >= DEPTH_W'(MAX_DEPTH)) begin
            mode_nxt = M_ERR;
            ev.kind  = EV_ERR;
            ev.value = ERR_TOO_DEEP;
          end else begin
            depth_nxt = depth_c + DEPTH_W'(1);
            mode_nxt  = M_NEEDWS;
            ev.kind   = EV_OPEN;
          end
        end else if (byte_in == CH_RPAREN && depth_c != '0) begin
          depth_nxt = depth_c - DEPTH_W'(1);
          mode_nxt  = M_NEEDWS;
          ev_fire   = 1'b1;
          ev.kind   = EV_CLOSE;
        end else begin
          mode_nxt = M_ERR;
          ev_fire  = 1'b1;
          ev.kind  = EV_ERR;
          ev.value = ERR_MALFORMED;
        end
      end
      M_NUM: begin
        ev_fire = 1'b1;
        if (is_digit(byte_in)) begin
          if (acc_ovf) begin
            mode_nxt = M_ERR;
            ev.kind  = EV_ERR;
            ev.value = ERR_OVERFLOW;
          end else begin
            acc_nxt = acc_x10[VAL_W-1:0];
            ev_fire = 1'b0;
          end
        end else if (byte_in == CH_COLON) begin
          rem_nxt  = acc_c;
          mode_nxt = (acc_c == '0) ? M_NEEDWS : M_STR;
          ev.kind  = EV_SHDR;
          ev.value = acc_c;
        end else if (is_ws(byte_in)) begin
          mode_nxt = M_IDLE;
          ev.kind  = EV_NUM;
          ev.value = acc_c;
        end else begin
          mode_nxt = M_ERR;
          ev.kind  = EV_ERR;
          ev.value = ERR_MALFORMED;
        end
      end
      M_STR: begin
        rem_nxt  = rem_dec;
        ev_fire  = 1'b1;
        ev.kind  = EV_SBYTE;
        ev.value = byte_val;
        if (rem_dec == '0) begin
          mode_nxt = M_NEEDWS;
          ev.last  = 1'b1;
        end
      end
      M_WORD: begin
        ev_fire = 1'b1;
        if (is_alpha(byte_in) || is_digit(byte_in) || byte_in == CH_MINUS) begin
          ev.kind  = EV_WBYTE;
          ev.value = byte_val;
        end else if (is_ws(byte_in)) begin
          mode_nxt = M_IDLE;
          ev.kind  = EV_WEND;
        end else begin
          mode_nxt = M_ERR;
          ev.kind  = EV_ERR;
          ev.value = ERR_MALFORMED;
        end
      end
      M_NEEDWS: begin
        if (is_ws(byte_in)) begin
          mode_nxt = M_IDLE;
        end else begin
          mode_nxt = M_ERR;
          ev_fire  = 1'b1;
          ev.kind  = EV_ERR;
          ev.value = ERR_MALFORMED;
        end
      end
      default: begin
        mode_nxt = mode_c;
      end
    endcase

    // The reported depth is the depth after this byte's update.
    ev.depth = NEST_W'(depth_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      acc_r   <= '0;
      rem_r   <= '0;
      depth_r <= '0;
      slp_r   <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      depth_r <= depth_nxt;
      slp_r   <= slp_nxt;
    end
  end

endmodule

FILE: hw/rtl/lplt_out_stage.sv
// Result register that holds one event until the sink takes the beat.
module lplt_out_stage import lplt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  event_t         ev,
  output logic           free,
  lplt_out_if.source     out_ch
);

  logic   valid_r;
  event_t ev_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      ev_r <= ev;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.event_kind       = ev_r.kind;
  assign out_ch.event_value      = ev_r.value;
  assign out_ch.nesting_depth    = ev_r.depth;
  assign out_ch.last_string_byte = ev_r.last;

endmodule

FILE: hw/rtl/length_prefixed_list_tokenizer_top.sv
// Top level of the length-prefixed list tokenizer.
//
//   channel   direction  beat contents
//   in_ch     sink       data_byte, restart
//   out_ch    source     event_kind, event_value, nesting_depth, last_string_byte
//   cfg_ch    sink       hunt_for_start
//
// One byte per cycle unless the output stalls: a byte sits in the input register,
// the parser updates its state and fills the result register in that same cycle.
// The 64-bit multiply-by-ten add with its overflow carry sets the clock period.
// A stalled result register holds the byte in the input register and drops
// in_ch.ready. Reset clears all parse state and hunt_for_start; cfg_ch is always ready.
module length_prefixed_list_tokenizer_top import lplt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lplt_in_if.sink     in_ch,
  lplt_out_if.source  out_ch,
  lplt_cfg_if.sink    cfg_ch
);

  logic       v0_r;
  logic [7:0] byte0_r;
  logic       restart0_r;
  logic       hunt_r;
  logic       out_free;
  logic       step;
  logic       ev_fire;
  event_t     ev;

  assign step        = v0_r && out_free;
  assign in_ch.ready = !v0_r || out_free;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ch.ready) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte0_r    <= in_ch.data_byte;
      restart0_r <= in_ch.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      hunt_r <= cfg_ch.hunt_for_start;
    end
  end

  lplt_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (byte0_r),
    .restart (restart0_r),
    .hunt    (hunt_r),
    .ev_fire (ev_fire),
    .ev      (ev)
  );

  lplt_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (step && ev_fire),
    .ev     (ev),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

FILE: tb/lplt_checker.sv
// Event predictor and output checker for the length-prefixed list tokenizer.
module lplt_checker import lplt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lplt_in_if   in_ch,
  lplt_out_if  out_ch,
  lplt_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam logic [VAL_W-1:0] RADIX    = 64'd10;
  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  logic              hunt_sel;
  logic [MODE_W-1:0] mode;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  remaining;
  logic [NEST_W-1:0] depth;
  logic              paren_seen;
  event_t            events_due[$];
  event_t            seen;
  event_t            want;
  int                errs = 0;

  function automatic logic blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_NL;
  endfunction

  function automatic logic digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic void clear_state();
    mode       = hunt_sel ? M_HUNT : M_IDLE;
    acc        = '0;
    remaining  = '0;
    depth      = '0;
    paren_seen = 1'b0;
  endfunction

  // The depth reported is the one after the event, so callers update it first.
  function automatic void emit_event(input logic [KIND_W-1:0] kind,
                                     input logic [VAL_W-1:0] value, input logic last);
    event_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.depth = depth;
    ev.last  = last;
    events_due.push_back(ev);
  endfunction

  function automatic void fault(input logic [VAL_W-1:0] code);
    mode = M_ERR;
    emit_event(EV_ERR, code, 1'b0);
  endfunction

  function automatic void tokenize(input logic [7:0] b, input logic rs);
    logic [VAL_W-1:0] d;
    if (rs)
      clear_state();
    case (mode)
      M_HUNT: begin
        if (paren_seen && blank(b)) begin
          paren_seen = 1'b0;
          depth      = 7'd1;
          mode       = M_IDLE;
          emit_event(EV_OPEN, '0, 1'b0);
        end else begin
          paren_seen = (b == CH_LPAREN);
        end
      end
      M_IDLE: begin
        if (blank(b)) begin
        end else if (digit(b)) begin
          acc  = {56'd0, b - CH_ZERO};
          mode = M_NUM;
        end else if (letter(b)) begin
          mode = M_WORD;
          emit_event(EV_WBYTE, {56'd0, b}, 1'b0);
        end else if (b == CH_LPAREN) begin
          if (depth >= MAX_DEPTH) begin
            fault(ERR_TOO_DEEP);
          end else begin
            depth = depth + 7'd1;
            mode  = M_NEEDWS;
            emit_event(EV_OPEN, '0, 1'b0);
          end
        end else if (b == CH_RPAREN && depth != 0) begin
          depth = depth - 7'd1;
          mode  = M_NEEDWS;
          emit_event(EV_CLOSE, '0, 1'b0);
        end else begin
          fault(ERR_MALFORMED);
        end
      end
      M_NUM: begin
        if (digit(b)) begin
          d = {56'd0, b - CH_ZERO};
          if (acc > (ALL_ONES - d) / RADIX)
            fault(ERR_OVERFLOW);
          else
            acc = acc * RADIX + d;
        end else if (b == CH_COLON) begin
          remaining = acc;
          mode      = (acc == 0) ? M_NEEDWS : M_STR;
          emit_event(EV_SHDR, acc, 1'b0);
        end else if (blank(b)) begin
          mode = M_IDLE;
          emit_event(EV_NUM, acc, 1'b0);
        end else begin
          fault(ERR_MALFORMED);
        end
      end
      M_STR: begin
        remaining = remaining - 64'd1;
        if (remaining == 0)
          mode = M_NEEDWS;
        emit_event(EV_SBYTE, {56'd0, b}, remaining == 0);
      end
      M_WORD: begin
        if (letter(b) || digit(b) || b == CH_MINUS) begin
          emit_event(EV_WBYTE, {56'd0, b}, 1'b0);
        end else if (blank(b)) begin
          mode = M_IDLE;
          emit_event(EV_WEND, '0, 1'b0);
        end else begin
          fault(ERR_MALFORMED);
        end
      end
      M_NEEDWS: begin
        if (blank(b))
          mode = M_IDLE;
        else
          fault(ERR_MALFORMED);
      end
      default: begin
      end
    endcase
  endfunction

  // An output beat can never stem from the input beat of the same edge,
  // so the output side is checked before the input side is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      hunt_sel = 1'b0;
      clear_state();
      events_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.kind  = out_ch.event_kind;
        seen.value = out_ch.event_value;
        seen.depth = out_ch.nesting_depth;
        seen.last  = out_ch.last_string_byte;
        if (events_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected event, none expected; got kind %0d value %0h depth %0d last %0b",
                   $time, seen.kind, seen.value, seen.depth, seen.last);
        end else begin
          want = events_due.pop_front();
          if (seen !== want) begin
            errs++;
            $display("%0t: event mismatch, expected kind %0d value %0h depth %0d last %0b",
                     $time, want.kind, want.value, want.depth, want.last);
            $display("%0t:                 got      kind %0d value %0h depth %0d last %0b",
                     $time, seen.kind, seen.value, seen.depth, seen.last);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready)
        hunt_sel = cfg_ch.hunt_for_start;
      if (in_ch.valid && in_ch.ready)
        tokenize(in_ch.data_byte, in_ch.restart);
    end
    pending    <= events_due.size();
    fail_count <= errs;
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: clock, reset, byte-stream stimulus with random gaps and stalls, and the verdict.
module tb_top import lplt_pkg::*;;

  localparam int LIMIT       = 1_000_000;
  localparam int PHASE_BEATS = 200;
  localparam int PHASES      = 6;
  localparam int DRAIN       = 8;

  localparam int MSG_GOOD     = 0;
  localparam int MSG_BROKEN   = 1;
  localparam int MSG_OVERFLOW = 2;
  localparam int MSG_DEEP     = 3;
  localparam int MSG_NOISE    = 4;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       calm;
  logic       rx_ready = 1'b0;
  int         stall_left = 0;
  int         cycles = 0;
  int         fail_count;
  int         pending;
  logic [8:0] msg_q[$];

  lplt_in_if  in_ch();
  lplt_out_if out_ch();
  lplt_cfg_if cfg_ch();

  assign out_ch.ready = rx_ready;

  length_prefixed_list_tokenizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lplt_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      rx_ready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rx_ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) < 2)
        stall_left <= gap_len();
    end
  end

  function automatic void put(input logic [7:0] b);
    msg_q.push_back({1'b0, b});
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++)
      put(s[i]);
  endfunction

  function automatic void put_ws();
    put($urandom_range(0, 3) == 0 ? CH_NL : CH_SPACE);
    if ($urandom_range(0, 9) == 0)
      put(CH_SPACE);
  endfunction

  function automatic void put_number(input logic [63:0] v);
    logic [7:0]  digs[$];
    logic [63:0] x;
    x = v;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) put(CH_ZERO);
    do begin
      digs.push_front(CH_ZERO + 8'(x % 64'd10));
      x = x / 64'd10;
    end while (x != 0);
    foreach (digs[i])
      put(digs[i]);
  endfunction

  function automatic void put_atom();
    int r;
    int len;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: begin
        if (r < 50)
          put_number($urandom_range(0, 999));
        else if (r < 70)
          put_number({$urandom, $urandom});
        else if (r < 80)
          put_number('1);
        else if (r < 90)
          put_number(64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 20));
        else
          put_number($urandom);
      end
      1: begin
        len = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        put_number(len);
        put(CH_COLON);
        repeat (len) put(8'($urandom_range(0, 255)));
      end
      default: begin
        put($urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 25))
                                 : 8'h61 + 8'($urandom_range(0, 25)));
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0: put(8'h41 + 8'($urandom_range(0, 25)));
            1: put(8'h61 + 8'($urandom_range(0, 25)));
            2: put(CH_ZERO + 8'($urandom_range(0, 9)));
            default: put(CH_MINUS);
          endcase
        end
      end
    endcase
    put_ws();
  endfunction

  function automatic void put_body(input int n);
    int open_n;
    int i;
    int r;
    open_n = 0;
    i = 0;
    while (i < n || open_n > 0) begin
      r = $urandom_range(0, 99);
      if (open_n > 0 && (i >= n || r < 25)) begin
        put(CH_RPAREN);
        put_ws();
        open_n--;
      end else if (open_n < 5 && r < 50) begin
        put(CH_LPAREN);
        put_ws();
        open_n++;
      end else begin
        put_atom();
      end
      i++;
    end
  endfunction

  // In hunt mode: junk the block must skip, then the opening paren of the first list.
  // Returns how many junk bytes lead the message.
  function automatic int put_lead(input logic hunting);
    logic [7:0] b;
    int         junk;
    if (!hunting)
      return 0;
    repeat ($urandom_range(0, 5)) begin
      b = 8'($urandom_range(0, 255));
      put(b == CH_LPAREN ? CH_RPAREN : b);
    end
    if ($urandom_range(0, 3) == 0) begin
      put(CH_LPAREN);
      put("q");
    end
    junk = msg_q.size();
    put(CH_LPAREN);
    put_ws();
    return junk;
  endfunction

  function automatic int put_good(input logic hunting);
    int lead;
    lead = put_lead(hunting);
    put_body($urandom_range(1, 6));
    if (hunting) begin
      put(CH_RPAREN);
      put_ws();
    end
    return lead;
  endfunction

  function automatic int put_message(input int kind, input logic hunting);
    int lead;
    int idx;
    int k;
    lead = 0;
    case (kind)
      MSG_GOOD:
        lead = put_good(hunting);
      MSG_BROKEN: begin
        lead = put_good(hunting);
        idx = $urandom_range(lead, msg_q.size() - 1);
        if ($urandom_range(0, 1))
          msg_q[idx] = {1'b0, 8'($urandom_range(0, 255))};
        else
          msg_q.delete(idx);
      end
      MSG_OVERFLOW: begin
        lead = put_lead(hunting);
        case ($urandom_range(0, 2))
          0: begin
            put_text("18446744073709551615");
            put(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          1: begin
            put_text("1844674407370955161");
            put(CH_ZERO + 8'($urandom_range(6, 9)));
          end
          default: begin
            put(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(20, 24)) put(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        endcase
        put_ws();
      end
      MSG_DEEP: begin
        lead = put_lead(hunting);
        k = $urandom_range(61, 66);
        repeat (k) begin
          put(CH_LPAREN);
          put_ws();
        end
        k = k + int'(hunting);
        repeat (k > MAX_DEPTH ? MAX_DEPTH : k) begin
          put(CH_RPAREN);
          put_ws();
        end
      end
      default: begin
        repeat ($urandom_range(4, 16)) begin
          case ($urandom_range(0, 7))
            0: put(CH_SPACE);
            1: put(CH_LPAREN);
            2: put(CH_RPAREN);
            3: put(CH_COLON);
            4: put(CH_ZERO + 8'($urandom_range(0, 9)));
            default: put(8'($urandom_range(0, 255)));
          endcase
        end
      end
    endcase
    return lead;
  endfunction

  // Holds valid high across back-to-back beats; lowers it only for a gap.
  task automatic push_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart   <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_msg();
    foreach (msg_q[i])
      push_byte(msg_q[i][7:0], msg_q[i][8]);
    msg_q.delete();
  endtask

  // Bytes that cause no event may still be in flight when the last event lands.
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_cfg(input logic hunt);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.hunt_for_start <= hunt;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic hunting;
    logic dirty;
    int   sent;
    int   lead;
    int   kind;
    int   r;
    int   msgs;

    rst_n                 <= 1'b0;
    calm                  <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.data_byte       <= 8'h00;
    in_ch.restart         <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.hunt_for_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_cfg(1'b0);

    // Directed: string with extreme bytes, a list with a word, an empty string,
    // a number, a close at top level, a byte after the error, a bad number
    // terminator and a byte that cannot start an item.
    put_text(" 3:a");
    put(8'h00);
    put(8'hFF);
    put(CH_NL);
    put_text("( x-9\n) 0: 7 )5");
    put_text("0x");
    put(8'hFF);
    msg_q[0][8]  = 1'b1;
    msg_q[22][8] = 1'b1;
    msg_q[24][8] = 1'b1;
    send_msg();
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      hunting = (phase % 2 == 0);
      write_cfg(hunting);
      dirty = 1'b1;
      sent  = 0;
      msgs  = 0;
      while (sent < PHASE_BEATS) begin
        calm <= ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (msgs == 1 && phase < 2)
          kind = MSG_DEEP;
        else if (r < 65)
          kind = MSG_GOOD;
        else if (r < 80)
          kind = MSG_BROKEN;
        else if (r < 87)
          kind = MSG_OVERFLOW;
        else if (r < 92)
          kind = MSG_DEEP;
        else
          kind = MSG_NOISE;
        lead = put_message(kind, hunting);
        // Hunting only starts on a restart, and an error sticks until one.
        if (hunting || dirty || $urandom_range(0, 3) == 0)
          msg_q[0][8] = 1'b1;
        dirty = (kind != MSG_GOOD);
        for (int i = 1; i < msg_q.size(); i++) begin
          if ($urandom_range(0, 199) == 0) begin
            msg_q[i][8] = 1'b1;
            dirty = 1'b1;
          end
        end
        sent += msg_q.size() - lead;
        msgs++;
        send_msg();
      end
      settle();
    end

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
